// ----- hw/rtl/hta_pkg.sv -----
// ----------------------------------------------------------------------------
// hta_pkg
// shared types and constants of the handle table allocator
// ----------------------------------------------------------------------------
package hta_pkg;

  localparam int OP_W         = 2;
  localparam int HANDLE_W     = 8;
  localparam int VALUE_W      = 32;
  localparam int NEW_HANDLE_W = 6;
  localparam int STATUS_W     = 2;

  localparam int IN_DATA_W  = ((HANDLE_W + VALUE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((NEW_HANDLE_W + VALUE_W + 7) / 8) * 8;

  // widest group of slot-in-use bits examined in one scan step
  localparam int MAX_CHUNK  = 16;
  localparam int FIND_OFF_W = $clog2(MAX_CHUNK);

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_GET    = 2'd1,
    OP_SET    = 2'd2,
    OP_REMOVE = 2'd3
  } hta_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_BAD_HANDLE = 2'd1,
    ST_FULL       = 2'd2
  } hta_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_READ,
    S_DONE
  } hta_state_t;

  typedef struct packed {
    logic                  found;
    logic                  last;
    logic [FIND_OFF_W-1:0] offset;
  } hta_find_t;

endpackage

// ----- hw/rtl/hta_free_find.sv -----
// ----------------------------------------------------------------------------
// hta_free_find
// priority encoder over one group of slot-in-use bits, lowest free slot wins
// ----------------------------------------------------------------------------
module hta_free_find #(
  parameter int CHUNK  = 16,
  parameter int BASE_W = 6,
  parameter int CMP_W  = 7
) (
  input  logic [CHUNK-1:0]  used,
  input  logic [BASE_W-1:0] base,
  input  logic [CMP_W-1:0]  hw,
  output hta_pkg::hta_find_t res
);
  import hta_pkg::*;

  logic [CHUNK-1:0] free_slot;

  always_comb begin
    for (int j = 0; j < CHUNK; j++) begin
      free_slot[j] = !used[j] && ((CMP_W'(base) + CMP_W'(j)) < hw);
    end
  end

  always_comb begin
    res.found  = 1'b0;
    res.offset = '0;
    // descending so the lowest free slot is the one left standing
    for (int j = CHUNK - 1; j >= 0; j--) begin
      if (free_slot[j]) begin
        res.found  = 1'b1;
        res.offset = FIND_OFF_W'(j);
      end
    end
    // no slot below the high-water mark lies beyond this group
    res.last = (CMP_W'(base) + CMP_W'(CHUNK)) >= hw;
  end

endmodule

// ----- hw/rtl/handle_table_allocator_top.sv -----
// ----------------------------------------------------------------------------
// handle_table_allocator_top
// fixed-capacity handle table: add, get, set and remove on a slot memory
// ----------------------------------------------------------------------------
// One request at a time. A get of a handle below the high-water mark passes
// through the execute, read and done states; set, remove and any request with
// a bad handle pass through execute and done. Add walks the in-use bits in
// groups of up to 16 slots, one group per scan step, until it finds an empty
// slot or reaches the high-water mark: it walks through 1 to ceil(CAPACITY/16)
// groups, then goes to done. The slot memory has a single port. A result may
// wait in the output register while the next request is taken. There is no
// clearing pass after reset: slots above the high-water mark are never read.
module handle_table_allocator_top #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [7:0] handle, [39:8] value
  input  logic [hta_pkg::IN_DATA_W-1:0]      in_tdata,
  // [1:0] operation
  input  logic [hta_pkg::OP_W-1:0]           in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [5:0] new_handle, [37:6] read_value, [39:38] zero
  output logic [hta_pkg::OUT_DATA_W-1:0]     out_tdata,
  // [1:0] status
  output logic [hta_pkg::STATUS_W-1:0]       out_tuser
);
  import hta_pkg::*;

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int HW_W   = $clog2(CAPACITY + 1);
  localparam int CHUNK  = (CAPACITY >= MAX_CHUNK) ? MAX_CHUNK : (1 << IDX_W);
  localparam int OFF_W  = $clog2(CHUNK);
  localparam int NCHUNK = (CAPACITY + CHUNK - 1) / CHUNK;
  localparam int CH_IW  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int BASE_W = CH_IW + OFF_W;
  localparam int CMP_W  = BASE_W + 1;
  localparam int PAD    = NCHUNK * CHUNK;
  localparam int HCMP_W = (HW_W > HANDLE_W) ? HW_W : HANDLE_W;

  hta_state_t state_r, state_nxt;

  hta_op_t                 op_r, op_nxt;
  logic [HANDLE_W-1:0]     handle_r, handle_nxt;
  logic [VALUE_BITS-1:0]   value_r, value_nxt;
  logic [CH_IW-1:0]        chunk_r, chunk_nxt;
  logic [HW_W-1:0]         hw_r, hw_nxt;

  logic [IDX_W-1:0]        res_handle_r, res_handle_nxt;
  logic [VALUE_BITS-1:0]   res_value_r, res_value_nxt;
  hta_status_t             res_status_r, res_status_nxt;

  logic                    out_valid_r;
  logic [NEW_HANDLE_W-1:0] out_handle_r;
  logic [VALUE_W-1:0]      out_value_r;
  hta_status_t             out_status_r;

  // slot memory and one in-use bit per slot
  logic [VALUE_BITS-1:0]   slots_r [CAPACITY];
  logic [VALUE_BITS-1:0]   rd_data_r;
  logic [PAD-1:0]          used_r;

  logic                    mem_we;
  logic [IDX_W-1:0]        mem_addr;
  logic [VALUE_BITS-1:0]   mem_wdata;
  logic                    hw_inc;

  logic                    in_fire;
  logic                    out_load;
  logic                    in_range;
  logic                    hw_full;
  logic [CHUNK-1:0]        chunk_used;
  logic [BASE_W-1:0]       chunk_base;
  logic [IDX_W-1:0]        found_idx;
  logic [IDX_W-1:0]        handle_idx;
  hta_find_t               find_res;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_load   = (state_r == S_DONE) && (!out_valid_r || out_tready);
  assign in_range   = HCMP_W'(handle_r) < HCMP_W'(hw_r);
  assign hw_full    = (hw_r == HW_W'(CAPACITY));
  assign handle_idx = IDX_W'(handle_r);
  assign chunk_base = {chunk_r, OFF_W'(0)};
  assign chunk_used = used_r[chunk_r * CHUNK +: CHUNK];
  assign found_idx  = IDX_W'({chunk_r, find_res.offset[OFF_W-1:0]});

  hta_free_find #(
    .CHUNK  (CHUNK),
    .BASE_W (BASE_W),
    .CMP_W  (CMP_W)
  ) u_find (
    .used (chunk_used),
    .base (chunk_base),
    .hw   (CMP_W'(hw_r)),
    .res  (find_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (hta_op_t'(in_tuser) == OP_ADD) ? S_SCAN : S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = (in_range && op_r == OP_GET) ? S_READ : S_DONE;
      end
      S_SCAN: begin
        if (find_res.found || find_res.last) begin
          state_nxt = S_DONE;
        end
      end
      S_READ: state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    op_nxt         = op_r;
    handle_nxt     = handle_r;
    value_nxt      = value_r;
    chunk_nxt      = chunk_r;
    res_handle_nxt = res_handle_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    mem_we         = 1'b0;
    mem_addr       = handle_idx;
    mem_wdata      = value_r;
    hw_inc         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt         = hta_op_t'(in_tuser);
          handle_nxt     = in_tdata[HANDLE_W-1:0];
          value_nxt      = VALUE_BITS'(in_tdata[HANDLE_W +: VALUE_W]);
          chunk_nxt      = '0;
          res_handle_nxt = '0;
          res_value_nxt  = '0;
          res_status_nxt = ST_OK;
        end
      end
      S_EXEC: begin
        if (!in_range) begin
          res_status_nxt = ST_BAD_HANDLE;
        end else begin
          unique case (op_r)
            OP_SET:    mem_we = 1'b1;
            OP_REMOVE: begin
              mem_we    = 1'b1;
              mem_wdata = '0;
            end
            OP_GET, OP_ADD: mem_we = 1'b0;
            default:        mem_we = 1'b0;
          endcase
        end
      end
      S_SCAN: begin
        priority if (find_res.found) begin
          mem_we         = 1'b1;
          mem_addr       = found_idx;
          res_handle_nxt = found_idx;
        end else if (find_res.last) begin
          if (hw_full) begin
            res_status_nxt = ST_FULL;
          end else begin
            // append at the high-water mark
            mem_we         = 1'b1;
            mem_addr       = IDX_W'(hw_r);
            res_handle_nxt = IDX_W'(hw_r);
            hw_inc         = 1'b1;
          end
        end else begin
          chunk_nxt = chunk_r + CH_IW'(1);
        end
      end
      S_READ: res_value_nxt = rd_data_r;
      S_DONE: res_value_nxt = res_value_r;
      default: res_value_nxt = res_value_r;
    endcase
  end

  assign hw_nxt = hw_inc ? (hw_r + HW_W'(1)) : hw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hw_r    <= hw_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    handle_r     <= handle_nxt;
    value_r      <= value_nxt;
    chunk_r      <= chunk_nxt;
    res_handle_r <= res_handle_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    if (out_load) begin
      out_handle_r <= NEW_HANDLE_W'(res_handle_r);
      out_value_r  <= VALUE_W'(res_value_r);
      out_status_r <= res_status_r;
    end
  end

  // slot memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slots_r[mem_addr] <= mem_wdata;
    end
    rd_data_r <= slots_r[mem_addr];
  end

  // a zero value leaves the slot free
  always_ff @(posedge clk) begin
    if (mem_we) begin
      used_r[mem_addr] <= (mem_wdata != '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - NEW_HANDLE_W - VALUE_W)'(0), out_value_r, out_handle_r};
  assign out_tuser  = out_status_r;

`ifndef SYNTH
  a_hw_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> hw_r >= $past(hw_r))
    else $error("high-water mark went down");

  a_full_only_at_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && res_status_r == ST_FULL) |-> hw_full)
    else $error("full status below capacity");

  a_add_below_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && op_r == OP_ADD && res_status_r == ST_OK)
      |-> HW_W'(res_handle_r) < hw_r)
    else $error("added handle not below high-water mark");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_DONE))
    else $error("result presented without a finished request");
`endif

endmodule

// ----- dv/tb_handle_table_allocator_top.sv -----
// ----------------------------------------------------------------------------
// tb_handle_table_allocator_top
// self-checking bench for the handle table allocator
// ----------------------------------------------------------------------------
// Requests go in through a streaming sender task. A table model inside the
// bench predicts every response at the moment the request is accepted.
// A monitor compares each response transaction, field by field, against the
// oldest prediction. A directed pass covers the empty table, zero values and
// bad handles. A fill pass drives the table to full and works on it there.
// Random passes follow with no idling, sender gaps, receiver stalls and both.
// ----------------------------------------------------------------------------
module tb_handle_table_allocator_top;
  import hta_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int TBL_IDX_W   = $clog2(TABLE_DEPTH);

  typedef struct packed {
    logic [NEW_HANDLE_W-1:0] new_handle;
    logic [VALUE_W-1:0]      read_value;
    hta_status_t             status;
  } table_result_t;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  logic [IN_DATA_W-1:0]    in_tdata   = '0;
  logic [OP_W-1:0]         in_tuser   = OP_ADD;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   out_tdata;
  logic [STATUS_W-1:0]     out_tuser;

  // table model
  logic [VALUE_W-1:0]      slot_mem [TABLE_DEPTH];
  int                      mark = 0;

  table_result_t           response_q [$];
  int                      error_count    = 0;
  int                      send_idle_pct  = 0;
  int                      recv_stall_pct = 0;

  handle_table_allocator_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    error_count++;
  endtask

  // updates the table model and returns the response the request should give
  function automatic table_result_t table_predict(input hta_op_t op,
                                                  input logic [HANDLE_W-1:0] handle,
                                                  input logic [VALUE_W-1:0] value);
    table_result_t r;
    int            free_idx;
    r.new_handle = '0;
    r.read_value = '0;
    r.status     = ST_OK;
    free_idx     = -1;
    if (op == OP_ADD) begin
      for (int i = 0; i < mark && free_idx < 0; i++) begin
        if (slot_mem[TBL_IDX_W'(i)] == '0) free_idx = i;
      end
      if (free_idx >= 0) begin
        slot_mem[TBL_IDX_W'(free_idx)] = value;
        r.new_handle = free_idx[NEW_HANDLE_W-1:0];
      end else if (mark >= TABLE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        slot_mem[TBL_IDX_W'(mark)] = value;
        r.new_handle = mark[NEW_HANDLE_W-1:0];
        mark++;
      end
    end else if (int'(handle) >= mark) begin
      r.status = ST_BAD_HANDLE;
    end else begin
      case (op)
        OP_GET: begin
          r.read_value = slot_mem[handle[TBL_IDX_W-1:0]];
        end
        OP_SET: begin
          slot_mem[handle[TBL_IDX_W-1:0]] = value;
        end
        default: begin
          slot_mem[handle[TBL_IDX_W-1:0]] = '0;
        end
      endcase
    end
    return r;
  endfunction

  // called at a rising edge; returns at the edge where the request is taken
  task automatic send_request(input hta_op_t op, input logic [HANDLE_W-1:0] handle,
                              input logic [VALUE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {value, handle};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    response_q.push_back(table_predict(op, handle, value));
  endtask

  task automatic wait_for_responses();
    in_tvalid <= 1'b0;
    while (response_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  always @(posedge clk) begin
    table_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (response_q.size() == 0) begin
        report_mismatch($sformatf("response with none pending, data %h status %0d",
                                  out_tdata, out_tuser));
      end else begin
        want = response_q.pop_front();
        if (out_tdata[NEW_HANDLE_W-1:0] !== want.new_handle)
          report_mismatch($sformatf("new_handle %0d, expected %0d",
                                    out_tdata[NEW_HANDLE_W-1:0], want.new_handle));
        if (out_tdata[NEW_HANDLE_W +: VALUE_W] !== want.read_value)
          report_mismatch($sformatf("read_value %h, expected %h",
                                    out_tdata[NEW_HANDLE_W +: VALUE_W], want.read_value));
        if (out_tdata[OUT_DATA_W-1:NEW_HANDLE_W+VALUE_W] !== '0)
          report_mismatch($sformatf("pad bits %b not zero",
                                    out_tdata[OUT_DATA_W-1:NEW_HANDLE_W+VALUE_W]));
        if (out_tuser !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_tuser, want.status));
      end
    end
  end

  // empty table, zero values, slot reuse and bad handles
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_request(OP_GET,    8'd0,   32'h1234_5678);
    send_request(OP_REMOVE, 8'd0,   32'h0);
    send_request(OP_SET,    8'd255, 32'hFFFF_FFFF);
    send_request(OP_ADD,    8'd0,   32'h0);          // zero stays free
    send_request(OP_ADD,    8'd255, 32'hFFFF_FFFF);  // reuses slot 0
    send_request(OP_ADD,    8'd0,   32'h0000_0001);
    send_request(OP_ADD,    8'd128, 32'h8000_0000);
    send_request(OP_GET,    8'd0,   32'h0);
    send_request(OP_GET,    8'd1,   32'hFFFF_FFFF);
    send_request(OP_GET,    8'd2,   32'h0);
    send_request(OP_GET,    8'd3,   32'h0);          // handle at the mark
    send_request(OP_GET,    8'd255, 32'h0);
    send_request(OP_SET,    8'd1,   32'h0);          // empties slot 1
    send_request(OP_ADD,    8'd7,   32'hA5A5_5A5A);  // back into slot 1
    send_request(OP_REMOVE, 8'd0,   32'hFFFF_FFFF);
    send_request(OP_REMOVE, 8'd200, 32'h0);
    send_request(OP_ADD,    8'd0,   32'h5A5A_A5A5);
    send_request(OP_SET,    8'd2,   32'h7FFF_FFFF);
    send_request(OP_GET,    8'd2,   32'h0);
    send_request(OP_GET,    8'd0,   32'h0);
    send_request(OP_SET,    8'd3,   32'h0);
    wait_for_responses();
  endtask

  // fill to capacity, then overflow, free and refill
  task automatic test_table_full();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (mark < TABLE_DEPTH) begin
      send_request(OP_ADD, 8'($urandom_range(255)), $urandom | 32'h1);
    end
    send_request(OP_ADD,    8'd0,   32'hDEAD_BEEF);
    send_request(OP_GET,    8'd63,  32'h0);
    send_request(OP_GET,    8'd64,  32'h0);
    send_request(OP_SET,    8'd63,  32'hFFFF_FFFF);
    send_request(OP_GET,    8'd63,  32'h0);
    send_request(OP_REMOVE, 8'd40,  32'h0);
    send_request(OP_ADD,    8'd0,   32'h0000_0002);
    send_request(OP_ADD,    8'd0,   32'h0000_0003);
    send_request(OP_SET,    8'd10,  32'h0);
    send_request(OP_ADD,    8'd0,   32'h0);          // slot 10 stays free
    send_request(OP_ADD,    8'd0,   32'h0000_0004);
    send_request(OP_ADD,    8'd0,   32'h0000_0005);
    send_request(OP_REMOVE, 8'd63,  32'h0);
    send_request(OP_ADD,    8'd0,   32'hFFFF_FFFF);
    send_request(OP_REMOVE, 8'd255, 32'h0);
    wait_for_responses();
  endtask

  // requests mostly aimed at live handles, in bursts that fill or drain the table
  task automatic run_random_requests(input int count);
    int                  add_weight;
    int                  pick;
    hta_op_t             op;
    logic [HANDLE_W-1:0] handle;
    logic [VALUE_W-1:0]  value;
    add_weight = 50;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(3))
          0:       add_weight = 15;
          1:       add_weight = 45;
          2:       add_weight = 70;
          default: add_weight = 92;
        endcase
      end
      if ($urandom_range(99) < add_weight) op = OP_ADD;
      else op = hta_op_t'($urandom_range(3, 1));
      pick = $urandom_range(99);
      if (mark > 0 && pick < 82) handle = 8'($urandom_range(mark - 1));
      else if (pick < 88) handle = 8'(mark);
      else handle = 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 10) value = '0;
      else if (pick < 14) value = '1;
      else value = $urandom;
      send_request(op, handle, value);
    end
    wait_for_responses();
  endtask

  task automatic test_random_streaming();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_requests(290);
  endtask

  task automatic test_random_sender_gaps();
    send_idle_pct  = 88;
    recv_stall_pct = 0;
    run_random_requests(290);
  endtask

  task automatic test_random_receiver_stalls();
    send_idle_pct  = 0;
    recv_stall_pct = 88;
    run_random_requests(290);
  endtask

  task automatic test_random_both_idle();
    send_idle_pct  = 38;
    recv_stall_pct = 38;
    run_random_requests(290);
  endtask

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) slot_mem[TBL_IDX_W'(i)] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_table_full();
    test_random_streaming();
    test_random_sender_gaps();
    test_random_receiver_stalls();
    test_random_both_idle();
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d responses outstanding", response_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/hta_pkg.sv
hw/rtl/hta_free_find.sv
hw/rtl/handle_table_allocator_top.sv
dv/tb_handle_table_allocator_top.sv
